// File: src/ecc_pkg.sv
`timescale 1ns / 1ps

package ecc_pkg;

  localparam int FLOORS       = 5;
  localparam int GROUND_INDEX = 1;
  localparam int FLOOR_W      = 3;
  localparam int CNT_W        = 16;

  localparam logic [CNT_W-1:0] DOOR_TICKS_RST = CNT_W'(3000);
  localparam logic [CNT_W-1:0] CNT_MAX        = {CNT_W{1'b1}};
  localparam logic [FLOOR_W-1:0] GROUND_FLOOR = FLOOR_W'(GROUND_INDEX);

  typedef enum logic [2:0] {
    MODE_IDLE    = 3'd0,
    MODE_UP      = 3'd1,
    MODE_DOWN    = 3'd2,
    MODE_OPENING = 3'd3,
    MODE_OPEN    = 3'd4,
    MODE_CLOSING = 3'd5,
    MODE_ALARM   = 3'd6,
    MODE_PHONE   = 3'd7
  } mode_t;

  typedef enum logic [1:0] {
    MOTOR_STOP = 2'd0,
    MOTOR_UP   = 2'd1,
    MOTOR_DOWN = 2'd2
  } motor_t;

  // first field in the highest bits
  typedef struct packed {
    logic [FLOOR_W-1:0] call_floor;
    logic               call_valid;
    logic               phone_button;
    logic               alarm_button;
    logic               open_button;
    logic               close_button;
    logic               door_obstacle;
    logic               door_fully_closed;
    logic               door_fully_open;
    logic               on_floor;
    logic [FLOOR_W-1:0] sensed_floor;
    logic               overload;
  } item_t;

  typedef struct packed {
    logic               overload_lamp;
    logic               phone_ringing;
    logic               alarm_active;
    logic               door_close_pulse;
    logic               door_open_pulse;
    motor_t             motor_drive;
    logic [FLOOR_W-1:0] goal_floor;
    logic [FLOOR_W-1:0] car_floor;
    mode_t              mode;
  } result_t;

  localparam int IN_W  = $bits(item_t);
  localparam int OUT_W = $bits(result_t);

endpackage

// File: src/elevator_car_controller.sv
`timescale 1ns / 1ps

// elevator car controller, one tick item in, one status item out
//
// in_* stream: one transfer per millisecond tick with sensor levels,
//   buttons and an optional floor call
// out_* stream: one transfer per tick with mode, floors, held motor
//   command, door pulses and alarm, phone and overload levels
// cfg_*: write of the door open timeout in ticks; the user must write it only
//   while the block is idle, the block itself does not enforce it; takes effect from the next tick
//
// input transfer to result valid: through the input register, then the
//   result register; throughput: one tick per cycle while out_tready is
//   high, with a combinational state update between the two registers
// reset (rst_n low, synchronous): car idle at the ground floor, no calls
//   pending, motor stopped, timeout back to 3000 ticks, both streams empty
// receiver stall: the result register holds, the input register fills,
//   then in_tready drops until out_tready returns; no tick is lost
module elevator_car_controller
  import ecc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  // overload, sensed_floor[2:0], on_floor, door_fully_open,
  // door_fully_closed, door_obstacle, close_button, open_button,
  // alarm_button, phone_button, call_valid, call_floor[2:0]
  input  logic [IN_W-1:0]  in_tdata,
  output logic             out_tvalid,
  input  logic             out_tready,
  // mode[2:0], car_floor[2:0], goal_floor[2:0], motor_drive[1:0],
  // door_open_pulse, door_close_pulse, alarm_active, phone_ringing,
  // overload_lamp
  output logic [OUT_W-1:0] out_tdata,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  logic    item_valid;
  item_t   item;
  result_t result;
  logic    free;
  logic    advance;

  assign advance = item_valid && free;

  ecc_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ecc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .advance   (advance),
    .item      (item),
    .result    (result)
  );

  ecc_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .result     (result),
    .free       (free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: src/ecc_in_stage.sv
`timescale 1ns / 1ps

module ecc_in_stage
  import ecc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,
  input  logic             advance,
  output logic             item_valid,
  output item_t            item
);

  logic  valid_r;
  item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      item_r <= item_t'(in_tdata);
    end
  end

endmodule

// File: src/ecc_core.sv
`timescale 1ns / 1ps

module ecc_core
  import ecc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  input  logic             advance,
  input  item_t            item,
  output result_t          result
);

  logic [CNT_W-1:0]   ticks_r;
  mode_t              mode_r, mode_nxt;
  logic [FLOOR_W-1:0] floor_r, floor_nxt;
  logic [FLOOR_W-1:0] goal_r, goal_nxt;
  logic [FLOORS-1:0]  pend_r, pend_nxt;
  logic               ovl_r, ovl_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  motor_t             motor_r, motor_nxt;
  logic               alarm_r, alarm_nxt;
  logic               phone_r, phone_nxt;
  logic               lamp_r, lamp_nxt;

  logic               new_ovl;
  logic               ovl_gone;
  logic               ovl_close;
  logic [FLOORS-1:0]  pend_a;
  logic [FLOORS-1:0]  pend_s;
  mode_t              mode_o;
  mode_t              mode_s;
  logic [FLOOR_W-1:0] goal_s;
  logic               up_hit, dn_hit;
  logic [FLOOR_W-1:0] up_f, dn_f;
  logic               arrived;
  logic               open_pulse, close_pulse;
  logic               timeout;

  // call registration, overrides and call search
  always_comb begin
    new_ovl   = item.overload && !ovl_r;
    ovl_gone  = !item.overload && ovl_r;
    ovl_close = ovl_gone && item.close_button;

    pend_a = pend_r;
    if (item.call_valid &&
        ({1'b0, item.call_floor} < (FLOOR_W+1)'(FLOORS))) begin
      pend_a[item.call_floor] = 1'b1;
    end

    mode_o = mode_r;
    if (ovl_close) begin
      mode_o = MODE_CLOSING;
    end
    if (item.alarm_button) begin
      mode_o = MODE_ALARM;
    end
    if (item.phone_button) begin
      mode_o = MODE_PHONE;
    end
    if (item.open_button && (mode_o == MODE_IDLE || mode_o == MODE_OPEN ||
                             mode_o == MODE_CLOSING)) begin
      mode_o = MODE_OPENING;
    end

    // nearest call above, else nearest below
    up_hit = 1'b0;
    up_f   = '0;
    for (int f = FLOORS - 1; f >= 0; f--) begin
      if (pend_a[f] && (FLOOR_W'(f) > floor_r)) begin
        up_hit = 1'b1;
        up_f   = FLOOR_W'(f);
      end
    end
    dn_hit = 1'b0;
    dn_f   = '0;
    for (int f = 0; f < FLOORS; f++) begin
      if (pend_a[f] && (FLOOR_W'(f) < floor_r)) begin
        dn_hit = 1'b1;
        dn_f   = FLOOR_W'(f);
      end
    end

    mode_s = mode_o;
    goal_s = goal_r;
    pend_s = pend_a;
    if (mode_o == MODE_IDLE || mode_o == MODE_OPEN) begin
      priority if (up_hit) begin
        mode_s         = MODE_UP;
        goal_s         = up_f;
        pend_s[up_f]   = 1'b0;
      end else if (dn_hit) begin
        mode_s         = MODE_DOWN;
        goal_s         = dn_f;
        pend_s[dn_f]   = 1'b0;
      end
    end

    arrived = item.on_floor && (item.sensed_floor == goal_s);
    timeout = (cnt_r >= ticks_r) || item.close_button;
  end

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    floor_nxt = floor_r;
    goal_nxt  = goal_r;
    pend_nxt  = pend_a;
    ovl_nxt   = ovl_r;
    cnt_nxt   = cnt_r;
    motor_nxt = motor_r;
    alarm_nxt = alarm_r;
    phone_nxt = phone_r;
    lamp_nxt  = lamp_r;
    if (new_ovl) begin
      motor_nxt = MOTOR_STOP;
      if (!item.door_fully_open) begin
        mode_nxt = MODE_OPENING;
      end
      alarm_nxt = 1'b1;
      lamp_nxt  = 1'b1;
      ovl_nxt   = 1'b1;
    end else begin
      if (ovl_gone) begin
        alarm_nxt = 1'b0;
        lamp_nxt  = 1'b0;
      end
      if (ovl_close) begin
        ovl_nxt = 1'b0;
      end
      mode_nxt = mode_s;
      goal_nxt = goal_s;
      pend_nxt = pend_s;
      unique case (mode_s)
        MODE_UP, MODE_DOWN: begin
          motor_nxt = (mode_s == MODE_UP) ? MOTOR_UP : MOTOR_DOWN;
          if (arrived) begin
            motor_nxt = MOTOR_STOP;
            floor_nxt = goal_s;
            mode_nxt  = MODE_OPENING;
          end
        end
        MODE_OPENING: begin
          if (item.door_fully_open) begin
            mode_nxt = MODE_OPEN;
            cnt_nxt  = '0;
          end
        end
        MODE_OPEN: begin
          if (timeout) begin
            mode_nxt = MODE_CLOSING;
          end else if (cnt_r != CNT_MAX) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end
        end
        MODE_CLOSING: begin
          if (item.door_fully_closed) begin
            mode_nxt = MODE_IDLE;
          end
          if (item.door_obstacle) begin
            mode_nxt = MODE_OPENING;
          end
        end
        MODE_ALARM: begin
          alarm_nxt = item.alarm_button;
          if (!item.alarm_button) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_PHONE: begin
          phone_nxt = item.phone_button;
          if (!item.phone_button) begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_IDLE: begin
        end
      endcase
    end
  end

  // door command pulses
  always_comb begin
    open_pulse  = 1'b0;
    close_pulse = 1'b0;
    if (new_ovl) begin
      open_pulse = !item.door_fully_open;
    end else begin
      close_pulse = ovl_close;
      unique case (mode_s)
        MODE_OPENING: open_pulse = 1'b1;
        MODE_OPEN:    close_pulse = close_pulse || timeout;
        MODE_CLOSING: open_pulse = item.door_obstacle;
        MODE_IDLE, MODE_UP, MODE_DOWN, MODE_ALARM, MODE_PHONE: begin
        end
      endcase
    end
  end

  always_comb begin
    result.mode             = mode_nxt;
    result.car_floor        = floor_nxt;
    result.goal_floor       = goal_nxt;
    result.motor_drive      = motor_nxt;
    result.door_open_pulse  = open_pulse;
    result.door_close_pulse = close_pulse;
    result.alarm_active     = alarm_nxt;
    result.phone_ringing    = phone_nxt;
    result.overload_lamp    = lamp_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_r <= DOOR_TICKS_RST;
    end else if (cfg_we) begin
      ticks_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      floor_r <= GROUND_FLOOR;
      goal_r  <= GROUND_FLOOR;
      pend_r  <= '0;
      ovl_r   <= 1'b0;
      cnt_r   <= '0;
      motor_r <= MOTOR_STOP;
      alarm_r <= 1'b0;
      phone_r <= 1'b0;
      lamp_r  <= 1'b0;
    end else if (advance) begin
      mode_r  <= mode_nxt;
      floor_r <= floor_nxt;
      goal_r  <= goal_nxt;
      pend_r  <= pend_nxt;
      ovl_r   <= ovl_nxt;
      cnt_r   <= cnt_nxt;
      motor_r <= motor_nxt;
      alarm_r <= alarm_nxt;
      phone_r <= phone_nxt;
      lamp_r  <= lamp_nxt;
    end
  end

endmodule

// File: src/ecc_out_stage.sv
`timescale 1ns / 1ps

module ecc_out_stage
  import ecc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  result_t          result,
  output logic             free,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata
);

  logic    valid_r;
  result_t data_r;

  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (free) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

endmodule

// File: src/ecc_checker.sv
`timescale 1ns / 1ps

module ecc_checker
  import ecc_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // result held while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed during stall");

  // result stream empty after reset
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // input side never blocked while the result register is empty
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty result register");

  // car floor stays within the building
  a_floor_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ({1'b0, out_tdata[5:3]} < (FLOOR_W+1)'(FLOORS)))
    else $error("car floor out of range");

endmodule

bind elevator_car_controller ecc_checker u_ecc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
